### sv/aes128_cfb_cipher_core_defines.svh
// Assertion macros for the AES-128 CFB core.
`ifndef AES128_CFB_CIPHER_CORE_DEFINES_SVH
`define AES128_CFB_CIPHER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ACC_ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define ACC_ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/acc_pkg.sv
// Shared types, constants and AES helper functions.
`timescale 1ns / 1ps
package acc_pkg;
    localparam int BLOCK_BYTES = 16;
    localparam logic [7:0] PAD_FIVE  = 8'h35;
    localparam logic [7:0] PAD_SEVEN = 8'h37;
    localparam logic [2:0] REG_KEY_HI = 3'd0;
    localparam logic [2:0] REG_KEY_LO = 3'd1;
    localparam logic [2:0] REG_IV_HI  = 3'd2;
    localparam logic [2:0] REG_IV_LO  = 3'd3;
    localparam logic [2:0] REG_DIR    = 3'd4;
    localparam logic [2:0] REG_PAD    = 3'd5;
    localparam logic [63:0] IV_HI_RST = 64'h3132333435363738;
    localparam logic [63:0] IV_LO_RST = 64'h3930313233343536;

    // One queued input word.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_qword;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYGEN,
        ST_DATA,
        ST_PAD
    } t_state;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit word sits at bits [127-8i -: 8].
    function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
        return w[127 - 8 * i -: 8];
    endfunction

    // Next round key from the current one.
    function automatic logic [127:0] key_step(input logic [127:0] k,
                                              input logic [7:0] rcon);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
        tw = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // One AES round without key add; mix selects MixColumns.
    function automatic logic [127:0] round_fn(input logic [127:0] s, input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
                t[j + 4 * c] = sbox(byte_of(s, j + 4 * ((c + j) & 3)));
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            r[127 - 8 * i -: 8] = t[i];
        return r;
    endfunction
endpackage

### sv/acc_front.sv
// Input side: two-entry word queue between the stream slave and the back end.
`timescale 1ns / 1ps
module acc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  acc_pkg::t_qword i_word,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output acc_pkg::t_qword o_q_word
);
    `include "aes128_cfb_cipher_core_defines.svh"

    acc_pkg::t_qword r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word  = r_mem[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && o_q_valid;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_word;
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    `ACC_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "queue count overflow")
    `ACC_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, (r_cnt == 2'd2) && !w_pop, r_cnt == 2'd2, "full queue drained without pop")
    `ACC_ASSERT_IMPL(a_ptr_match, i_clk, i_rst_n, (r_cnt == 2'd1) ? (r_wp != r_rp) : (r_wp == r_rp), "pointer mismatch")
endmodule

### sv/acc_back.sv
// Back end: iterative AES-128 keystream unit, CFB feedback and output register.
`timescale 1ns / 1ps
module acc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [127:0]    i_key,
    input  logic [127:0]    i_iv,
    input  logic            i_dir,
    input  logic            i_pad_sel,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  acc_pkg::t_qword i_q_word,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last,
    output logic            o_err
);
    `include "aes128_cfb_cipher_core_defines.svh"

    acc_pkg::t_state r_state, n_state;
    logic [127:0] r_fb, n_fb;
    logic [127:0] r_ks, n_ks;
    logic [127:0] r_rk, n_rk;
    logic [7:0]   r_rcon, n_rcon;
    logic [3:0]   r_round, n_round;
    logic [3:0]   r_pos, n_pos;
    logic         r_start, n_start;
    logic         r_ov, n_ov;
    logic [7:0]   r_ob, n_ob;
    logic         r_ol, n_ol;
    logic         r_oe, n_oe;
    logic         w_slot;
    logic [7:0]   w_ksb, w_res, w_pad;
    logic [127:0] w_src;
    logic [6:0]   w_sh;

    assign w_slot = !r_ov || i_ready;
    assign w_sh   = {3'd0, 4'd15 - r_pos} << 3;
    assign w_ksb  = 8'(r_ks >> w_sh);
    assign w_pad  = i_pad_sel ? acc_pkg::PAD_SEVEN : acc_pkg::PAD_FIVE;
    assign w_src  = r_start ? i_iv : r_fb;

    // Sequencer
    always_comb begin
        n_state = r_state; n_fb = r_fb; n_ks = r_ks; n_rk = r_rk;
        n_rcon = r_rcon; n_round = r_round; n_pos = r_pos; n_start = r_start;
        n_ov = r_ov && !i_ready; n_ob = r_ob; n_ol = r_ol; n_oe = r_oe;
        o_q_pop = 1'b0;
        w_res = 8'h00;
        unique case (r_state)
            acc_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (r_pos == 4'd0) begin
                        // block start: initial key add
                        n_fb = w_src; n_start = 1'b0;
                        n_ks = w_src ^ i_key; n_rk = i_key;
                        n_rcon = 8'h01; n_round = 4'd1;
                        n_state = acc_pkg::ST_KEYGEN;
                    end else begin
                        n_state = acc_pkg::ST_DATA;
                    end
                end
            end
            acc_pkg::ST_KEYGEN: begin
                // one round per cycle
                n_rk = acc_pkg::key_step(r_rk, r_rcon);
                n_ks = acc_pkg::round_fn(r_ks, r_round != 4'd10) ^ n_rk;
                n_rcon = acc_pkg::xtime(r_rcon);
                n_round = r_round + 4'd1;
                if (r_round == 4'd10) n_state = acc_pkg::ST_DATA;
            end
            acc_pkg::ST_DATA: begin
                if (w_slot && i_q_valid) begin
                    o_q_pop = 1'b1;
                    w_res = i_q_word.data ^ w_ksb;
                    n_fb[127 - 8 * r_pos -: 8] = i_dir ? i_q_word.data : w_res;
                    n_ov = 1'b1; n_ob = w_res; n_ol = 1'b0; n_oe = 1'b0;
                    n_pos = r_pos + 4'd1;
                    n_state = acc_pkg::ST_IDLE;
                    if (i_q_word.last) begin
                        n_start = 1'b1;
                        if (i_dir) begin
                            n_ol = 1'b1; n_oe = (n_pos != 4'd0); n_pos = 4'd0;
                        end else if (n_pos == 4'd0) begin
                            n_ol = 1'b1;
                        end else begin
                            n_state = acc_pkg::ST_PAD;
                        end
                    end
                end
            end
            acc_pkg::ST_PAD: begin
                if (w_slot) begin
                    w_res = w_pad ^ w_ksb;
                    n_fb[127 - 8 * r_pos -: 8] = w_res;
                    n_ov = 1'b1; n_ob = w_res; n_oe = 1'b0;
                    n_ol = (r_pos == 4'd15);
                    n_pos = r_pos + 4'd1;
                    if (r_pos == 4'd15) n_state = acc_pkg::ST_IDLE;
                end
            end
            default: n_state = acc_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acc_pkg::ST_IDLE;
            r_pos <= 4'd0; r_start <= 1'b1; r_ov <= 1'b0;
            r_round <= 4'd0; r_rcon <= 8'h01;
        end else begin
            r_state <= n_state; r_pos <= n_pos; r_start <= n_start;
            r_ov <= n_ov; r_round <= n_round; r_rcon <= n_rcon;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_fb <= n_fb; r_ks <= n_ks; r_rk <= n_rk;
        r_ob <= n_ob; r_ol <= n_ol; r_oe <= n_oe;
    end

    assign o_valid = r_ov;
    assign o_byte  = r_ob;
    assign o_last  = r_ol;
    assign o_err   = r_oe;

    `ACC_ASSERT_IMPL(a_err_last, i_clk, i_rst_n, !(r_ov && r_oe) || r_ol, "error without last")
    `ACC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ov && !i_ready, r_ov && $stable(r_ob), "stalled output changed")
    `ACC_ASSERT_IMPL(a_pad_pos, i_clk, i_rst_n, (r_state != acc_pkg::ST_PAD) || (r_pos != 4'd0), "pad at block start")
endmodule

### sv/aes128_cfb_cipher_core.sv
// AES-128 CFB-128 byte stream core: top level with configuration registers.
// Each 16-byte block starts with a keystream computation of one AES round per
// cycle, after an initial key add. The first byte of a block then passes
// straight from the round computation to the data state; every later byte goes
// through a dispatch state and then the data state. An encrypted message
// ending mid-block is padded with encrypted pad bytes, one per cycle while
// the output is not stalled. Keys are expanded on the fly inside the round
// unit. Input words queue in a two-entry buffer; results leave through a
// registered output stage.
`timescale 1ns / 1ps
module aes128_cfb_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // out_last
    output logic        m_axis_tuser    // length_error
);
    logic [63:0] r_key_hi, r_key_lo, r_iv_hi, r_iv_lo;
    logic        r_dir, r_pad;
    logic        w_qv, w_pop;
    acc_pkg::t_qword w_in, w_qw;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0; r_key_lo <= '0;
            r_iv_hi <= acc_pkg::IV_HI_RST; r_iv_lo <= acc_pkg::IV_LO_RST;
            r_dir <= 1'b0; r_pad <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                acc_pkg::REG_KEY_HI: r_key_hi <= i_cfg_wdata;
                acc_pkg::REG_KEY_LO: r_key_lo <= i_cfg_wdata;
                acc_pkg::REG_IV_HI:  r_iv_hi <= i_cfg_wdata;
                acc_pkg::REG_IV_LO:  r_iv_lo <= i_cfg_wdata;
                acc_pkg::REG_DIR:    r_dir <= i_cfg_wdata[0];
                acc_pkg::REG_PAD:    r_pad <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_in.data = s_axis_tdata;
    assign w_in.last = s_axis_tlast;

    acc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_word(w_in),
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_word(w_qw)
    );

    acc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_key({r_key_hi, r_key_lo}), .i_iv({r_iv_hi, r_iv_lo}),
        .i_dir(r_dir), .i_pad_sel(r_pad),
        .i_q_valid(w_qv), .o_q_pop(w_pop), .i_q_word(w_qw),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_byte(m_axis_tdata), .o_last(m_axis_tlast), .o_err(m_axis_tuser)
    );
endmodule

### tb/sv/cfb_stream_checker.sv
// Stream checker for the AES-128 CFB core: predicts and compares results.
`timescale 1ns / 1ps
module cfb_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [63:0] i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_data,
    input  logic        i_out_last,
    input  logic        i_out_err,
    output int          o_fail_count,
    output int          o_pending
);
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_result;

    logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
    logic         decrypt, pad_seven;
    logic [7:0]   fb [16];
    logic [7:0]   ks [16];
    logic [3:0]   pos;
    logic         new_msg;
    t_result      expected_q [$];
    int           fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_q.size();

    // Plain AES-128 encryption with a key schedule of its own.
    function automatic logic [127:0] aes_encrypt(input logic [127:0] pt,
                                                 input logic [127:0] key);
        logic [7:0]   rk [176];
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   tmp [4];
        logic [7:0]   rc, a, b0, b1, b2, b3, al;
        logic [127:0] res;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) rk[i] = key[127 - 8 * i -: 8];
        for (int i = 16; i < 176; i += 4) begin
            for (int j = 0; j < 4; j++) tmp[j] = rk[i - 4 + j];
            if ((i % 16) == 0) begin
                a = tmp[0];
                tmp[0] = acc_pkg::sbox(tmp[1]) ^ rc;
                tmp[1] = acc_pkg::sbox(tmp[2]);
                tmp[2] = acc_pkg::sbox(tmp[3]);
                tmp[3] = acc_pkg::sbox(a);
                rc = acc_pkg::xtime(rc);
            end
            for (int j = 0; j < 4; j++) rk[i + j] = rk[i - 16 + j] ^ tmp[j];
        end
        for (int i = 0; i < 16; i++) st[i] = pt[127 - 8 * i -: 8] ^ rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int j = 0; j < 4; j++)
                    sh[j + 4 * c] = acc_pkg::sbox(st[j + 4 * ((c + j) % 4)]);
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    b0 = sh[4*c]; b1 = sh[4*c+1]; b2 = sh[4*c+2]; b3 = sh[4*c+3];
                    al = b0 ^ b1 ^ b2 ^ b3;
                    sh[4*c]   = b0 ^ al ^ acc_pkg::xtime(b0 ^ b1);
                    sh[4*c+1] = b1 ^ al ^ acc_pkg::xtime(b1 ^ b2);
                    sh[4*c+2] = b2 ^ al ^ acc_pkg::xtime(b2 ^ b3);
                    sh[4*c+3] = b3 ^ al ^ acc_pkg::xtime(b3 ^ b0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = sh[i] ^ rk[16 * r + i];
        end
        for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
        return res;
    endfunction

    // Advance the cipher state by one byte and queue its results.
    task automatic cipher_byte(input logic [7:0] din, input logic last);
        logic [127:0] blk, kso;
        logic [7:0]   r, padb;
        t_result      e;
        if (pos == 0) begin
            if (new_msg) begin
                for (int i = 0; i < 8; i++) begin
                    fb[i]     = iv_hi[63 - 8 * i -: 8];
                    fb[i + 8] = iv_lo[63 - 8 * i -: 8];
                end
                new_msg = 1'b0;
            end
            for (int i = 0; i < 16; i++) blk[127 - 8 * i -: 8] = fb[i];
            kso = aes_encrypt(blk, {key_hi, key_lo});
            for (int i = 0; i < 16; i++) ks[i] = kso[127 - 8 * i -: 8];
        end
        r = din ^ ks[pos];
        fb[pos] = decrypt ? din : r;
        pos = pos + 4'd1;
        e = '{data: r, last: 1'b0, err: 1'b0};
        if (last && decrypt) begin
            e.last = 1'b1;
            e.err  = (pos != 0);
        end else if (last) begin
            padb = pad_seven ? acc_pkg::PAD_SEVEN : acc_pkg::PAD_FIVE;
            while (pos != 0) begin
                expected_q.push_back(e);
                r = padb ^ ks[pos];
                fb[pos] = r;
                e = '{data: r, last: 1'b0, err: 1'b0};
                pos = pos + 4'd1;
            end
            e.last = 1'b1;
        end
        expected_q.push_back(e);
        if (last) begin
            pos = 4'd0;
            new_msg = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_result got, exp_r;
        if (!i_rst_n) begin
            key_hi = '0; key_lo = '0;
            iv_hi = acc_pkg::IV_HI_RST; iv_lo = acc_pkg::IV_LO_RST;
            decrypt = 1'b0; pad_seven = 1'b0;
            pos = 4'd0; new_msg = 1'b1;
            for (int i = 0; i < 16; i++) ks[i] = '0;
            expected_q.delete();
        end else begin
            // result side first: an input word cannot affect this edge's output
            if (i_out_valid && i_out_ready) begin
                got = '{data: i_out_data, last: i_out_last, err: i_out_err};
                if (expected_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected word: byte %h last %b err %b",
                                 got.data, got.last, got.err);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                                     exp_r.data, exp_r.last, exp_r.err,
                                     got.data, got.last, got.err);
                    end
                end
            end
            if (i_in_valid && i_in_ready) cipher_byte(i_in_data, i_in_last);
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    acc_pkg::REG_KEY_HI: key_hi = i_cfg_wdata;
                    acc_pkg::REG_KEY_LO: key_lo = i_cfg_wdata;
                    acc_pkg::REG_IV_HI:  iv_hi = i_cfg_wdata;
                    acc_pkg::REG_IV_LO:  iv_lo = i_cfg_wdata;
                    acc_pkg::REG_DIR:    decrypt = i_cfg_wdata[0];
                    acc_pkg::REG_PAD:    pad_seven = i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    initial fails = 0;
endmodule

### tb/sv/tb_top.sv
// Top of the AES-128 CFB core testbench: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;
    localparam int STALL_LIMIT = 4000;

    logic        i_clk, i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [63:0] cfg_wdata;
    logic        in_valid, in_ready, in_last;
    logic [7:0]  in_data;
    logic        out_valid, out_ready, out_last, out_err;
    logic [7:0]  out_data;
    int          fail_count, pending;
    int          idle_cycles;

    aes128_cfb_cipher_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .s_axis_tvalid(in_valid), .s_axis_tready(in_ready),
        .s_axis_tdata(in_data), .s_axis_tlast(in_last),
        .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
        .m_axis_tdata(out_data), .m_axis_tlast(out_last), .m_axis_tuser(out_err)
    );

    cfb_stream_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_in_data(in_data), .i_in_last(in_last),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_data(out_data), .i_out_last(out_last), .i_out_err(out_err),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side back-pressure, with no-stall stretches.
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) out_ready = 1'b1;
            else out_ready = (gap_len() == 0);
        end
    end

    // Watchdog on accepted words, delivered results and configuration writes.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        cfg_we = 1'b1; cfg_addr = idx; cfg_wdata = val;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Offer one input word and wait for acceptance.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int g;
        g = gap_len();
        repeat (g) @(negedge i_clk);
        in_valid = 1'b1; in_data = b; in_last = last;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
        in_valid = 1'b0;
    endtask

    // Wait for every expected result, then let the pipeline drain.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic send_msg(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    initial begin
        int len;
        in_valid = 1'b0; in_data = '0; in_last = 1'b0;
        cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: encrypt, a one-byte message padded with '5'.
        send_byte(8'h00, 1'b1);
        // Full block of extreme bytes, ends on a block boundary.
        for (int i = 0; i < 16; i++) send_byte(i[0] ? 8'hFF : 8'h00, i == 15);
        drain();
        // All-ones key, IV with all-ones upper and zero lower half, pad '7', a two-byte message.
        write_reg(acc_pkg::REG_KEY_HI, '1);
        write_reg(acc_pkg::REG_KEY_LO, '1);
        write_reg(acc_pkg::REG_IV_HI, '1);
        write_reg(acc_pkg::REG_IV_LO, '0);
        write_reg(acc_pkg::REG_PAD, 64'd1);
        write_reg(3'd7, rand64());
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        drain();
        // Decrypt: mid-block end raises the length error, then a clean block.
        write_reg(acc_pkg::REG_DIR, 64'd1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b1);
        send_msg(16);
        drain();

        // Random phases with fresh settings.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(acc_pkg::REG_KEY_HI, rand64());
            write_reg(acc_pkg::REG_KEY_LO, rand64());
            write_reg(acc_pkg::REG_IV_HI, rand64());
            write_reg(acc_pkg::REG_IV_LO, rand64());
            write_reg(acc_pkg::REG_DIR, 64'($urandom_range(0, 1)));
            write_reg(acc_pkg::REG_PAD, 64'($urandom_range(0, 1)));
            case ($urandom_range(0, 3))
                0: len = 16;
                1: len = 32;
                default: len = $urandom_range(1, 20);
            endcase
            send_msg(len);
            drain();
        end

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+sv
sv/acc_pkg.sv
sv/acc_front.sv
sv/acc_back.sv
sv/aes128_cfb_cipher_core.sv
tb/sv/cfb_stream_checker.sv
tb/sv/tb_top.sv
